// ===== src/ppgt_pkg.sv =====
`timescale 1ns / 1ps

package ppgt_pkg;

    // Default table geometry.
    localparam int SLOTS_DEFAULT      = 64;
    localparam int LEVEL_BITS_DEFAULT = 8;

    // Operation codes of an input item.
    localparam logic OP_SUBSCRIBE = 1'b0;
    localparam logic OP_RETIRE    = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [5:0] slot_id;
        logic [7:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic       holder_valid;
        logic [5:0] holder_slot;
        logic [7:0] holder_level;
        logic       started_active;
        logic       paused_valid;
        logic [5:0] paused_slot;
    } result_t;

endpackage

// ===== src/preemptive_priority_grant_table.sv =====
`timescale 1ns / 1ps

// Preemptive fixed-priority grant table. An item is taken at a rising edge
// where start is high and busy is low, and exactly one result item follows,
// shown on result for the single cycle in which done is high. The receiver
// cannot stall: capture result whenever done is high. A subscribe, a retire
// of a slot outside the table, and any item taken while the configured enable
// bit is low never raise busy, and the result appears in the cycle after the item
// is taken. A retire with the scheduler enabled rescans the whole table one
// entry per cycle through the single read port of the level memory and one
// shared compare unit; done is raised in the cycle busy falls, so a new item
// may be issued that cycle. The configuration register is written by cfg_we
// and cfg_wdata and must only be changed while the block is idle.
module preemptive_priority_grant_table
    import ppgt_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEFAULT,
    parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Table storage. Valid and awake flags are flops cleared at reset; levels live in a
    // memory whose read data is used only for valid entries.
    logic [LEVEL_BITS-1:0] level_mem [SLOTS];
    logic [SLOTS-1:0]      valid_reg;
    logic [SLOTS-1:0]      awake_reg;

    logic                  enable_reg;
    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // Scan pipeline: read stage, then compare stage.
    logic                  pend_reg, pend_next;
    logic                  v_pipe_reg;
    logic [SLOT_W-1:0]     idx_pipe_reg;
    logic [LEVEL_BITS-1:0] rd_level_reg;

    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     best_slot_reg, best_slot_next;
    logic [LEVEL_BITS-1:0] best_level_reg, best_level_next;

    // Grant holder.
    logic                  gv_reg, gv_next;
    logic [SLOT_W-1:0]     gs_reg, gs_next;
    logic [LEVEL_BITS-1:0] gl_reg, gl_next;

    logic                  done_reg, done_next;
    result_t               res_reg, res_next;

    logic                  accept;
    logic                  in_range;
    logic [SLOT_W-1:0]     slot_idx;
    logic [LEVEL_BITS-1:0] req_level;
    logic [SLOT_W-1:0]     scan_idx;

    logic                  mem_we;
    logic                  set_valid, clr_valid;
    logic                  wake_en, sleep_en;
    logic [SLOT_W-1:0]     wake_idx, sleep_idx;
    logic                  emit, started, paused_v;
    logic [SLOT_W-1:0]     paused_s;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;

    assign in_range  = (32'(cmd.slot_id) < 32'(SLOTS));
    assign slot_idx  = SLOT_W'(cmd.slot_id);
    assign req_level = LEVEL_BITS'(cmd.priority_req);

    // The counter runs one past the last entry to drain the compare stage.
    assign scan_idx  = (cnt_reg == CNT_LAST) ? '0 : cnt_reg[SLOT_W-1:0];
    assign pend_next = (state_reg == ST_SCAN) && (cnt_reg != CNT_LAST);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        best_slot_next  = best_slot_reg;
        best_level_next = best_level_reg;
        gv_next         = gv_reg;
        gs_next         = gs_reg;
        gl_next         = gl_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        mem_we          = 1'b0;
        set_valid       = 1'b0;
        clr_valid       = 1'b0;
        wake_en         = 1'b0;
        wake_idx        = slot_idx;
        sleep_en        = 1'b0;
        sleep_idx       = slot_idx;
        emit            = 1'b0;
        started         = 1'b0;
        paused_v        = 1'b0;
        paused_s        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    if (in_range)
                    begin
                        if (cmd.opcode == OP_SUBSCRIBE)
                        begin
                            set_valid = 1'b1;
                            mem_we    = 1'b1;
                            if (!enable_reg)
                            begin
                                started = 1'b1;
                            end
                            else if (!gv_reg || (req_level > gl_reg))
                            begin
                                // A different holder loses the grant and is put to sleep.
                                if (gv_reg && (gs_reg != slot_idx))
                                begin
                                    sleep_en  = 1'b1;
                                    sleep_idx = gs_reg;
                                    paused_v  = 1'b1;
                                    paused_s  = gs_reg;
                                end
                                gv_next = 1'b1;
                                gs_next = slot_idx;
                                gl_next = req_level;
                                wake_en = 1'b1;
                                started = 1'b1;
                            end
                        end
                        else
                        begin
                            clr_valid = 1'b1;
                            sleep_en  = 1'b1;
                            if (enable_reg)
                            begin
                                emit       = 1'b0;
                                state_next = ST_SCAN;
                                cnt_next   = '0;
                                found_next = 1'b0;
                            end
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
                // Highest level wins; the strict compare keeps the lowest slot on ties.
                if (pend_reg && v_pipe_reg && (!found_reg || (rd_level_reg > best_level_reg)))
                begin
                    found_next      = 1'b1;
                    best_slot_next  = idx_pipe_reg;
                    best_level_next = rd_level_reg;
                end
            end

            ST_FINISH:
            begin
                emit       = 1'b1;
                state_next = ST_IDLE;
                gv_next    = found_reg;
                gs_next    = found_reg ? best_slot_reg : '0;
                gl_next    = found_reg ? best_level_reg : '0;
                wake_en    = found_reg;
                wake_idx   = best_slot_reg;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            done_next               = 1'b1;
            res_next.holder_valid   = gv_next;
            res_next.holder_slot    = gv_next ? 6'(gs_next) : 6'd0;
            res_next.holder_level   = gv_next ? 8'(gl_next) : 8'd0;
            res_next.started_active = started;
            res_next.paused_valid   = paused_v;
            res_next.paused_slot    = 6'(paused_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            best_slot_reg  <= '0;
            best_level_reg <= '0;
            gv_reg         <= 1'b0;
            gs_reg         <= '0;
            gl_reg         <= '0;
            done_reg       <= 1'b0;
            res_reg        <= '0;
            valid_reg      <= '0;
            awake_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            best_slot_reg  <= best_slot_next;
            best_level_reg <= best_level_next;
            gv_reg         <= gv_next;
            gs_reg         <= gs_next;
            gl_reg         <= gl_next;
            done_reg       <= done_next;
            res_reg        <= res_next;
            if (set_valid)
            begin
                valid_reg[slot_idx] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[slot_idx] <= 1'b0;
            end
            if (sleep_en)
            begin
                awake_reg[sleep_idx] <= 1'b0;
            end
            if (wake_en)
            begin
                awake_reg[wake_idx] <= 1'b1;
            end
        end
    end

    // Level memory: one write port for subscribes, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[slot_idx] <= req_level;
        end
        rd_level_reg <= level_mem[scan_idx];
        v_pipe_reg   <= valid_reg[scan_idx];
        idx_pipe_reg <= scan_idx;
    end

endmodule
